// File: hw/rtl/kms_pkg.sv
package kms_pkg;

  // Sizing of the store
  localparam int MAX_KEYS       = 16;
  localparam int VALUES_PER_KEY = 8;

  localparam int KEY_AW  = $clog2(MAX_KEYS);
  localparam int KCNT_W  = $clog2(MAX_KEYS + 1);
  localparam int VCNT_W  = $clog2(VALUES_PER_KEY + 1);
  localparam int VAL_DEPTH = MAX_KEYS * VALUES_PER_KEY;
  localparam int VAL_AW  = $clog2(VAL_DEPTH);

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_FIND   = 1'b1
  } act_t;

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_KEYS_FULL = 3'd3,
    ST_LIST_FULL = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_RESP,
    S_FIND
  } state_t;

  typedef struct packed {
    act_t               action;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] found_value;
    logic               last;
  } rsp_t;

  // One key slot: value count next to the key itself
  typedef struct packed {
    logic [VCNT_W-1:0] cnt;
    logic [31:0]       key;
  } key_ent_t;

endpackage

// File: hw/rtl/key_multivalue_store.sv
// Key to multi-value store with a linear key search.
//
// Request channel (req_valid / req_stall / req): one transaction is an insert
// (key, value) or a find (key). Response channel (rsp_valid / rsp_stall / rsp):
// an insert gives one response (stored, key table full or value list full);
// a find gives one response per stored value of the key, oldest first, with
// last set on the final one, or a single not-found response.
//
// One request is processed at a time; req_stall is high while it is in work.
// The key search reads the key memory once per cycle over the used slots,
// then the block posts a single response. A find hit then streams its values
// out of the value memory at one per cycle while rsp_stall is low, with the
// next request taken in the cycle after the last response is posted.
//
// Reset clears the slot count and the response valid flag; memory contents are
// left as they are and only written entries are ever read.
// While rsp_stall is high and a response is valid, the response register holds and the block waits.
module key_multivalue_store
  import kms_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  // Memories
  key_ent_t           key_mem [MAX_KEYS];
  logic signed [31:0] val_mem [VAL_DEPTH];

  key_ent_t           key_rdata;
  logic signed [31:0] val_rdata;

  // Control registers
  state_t              state, state_next;
  req_t                cur;
  logic [KCNT_W-1:0]   keys_used;
  logic [KCNT_W-1:0]   issue_cnt;
  logic                cmp_vld;
  logic [KEY_AW-1:0]   cmp_idx;
  logic [KEY_AW-1:0]   slot;
  logic [VCNT_W-1:0]   fcnt;
  logic [VCNT_W-1:0]   fidx;
  logic                pend;
  logic                pend_last;
  status_t             resp_status;

  // Combinational controls
  logic                can_load;
  logic                hit;
  logic                issuing;
  logic                search_miss;
  logic                key_rd_en;
  logic [KEY_AW-1:0]   key_raddr;
  logic                key_we;
  logic [KEY_AW-1:0]   key_waddr;
  key_ent_t            key_wdata;
  logic                val_we;
  logic [VAL_AW-1:0]   val_waddr;
  logic                val_rd_en;
  logic [VAL_AW-1:0]   val_raddr;
  logic                resp_set;
  status_t             resp_status_next;
  logic                keys_inc;
  logic                find_init;
  logic                rsp_load_single;
  logic                rsp_load_val;

  assign can_load    = !rsp_valid || !rsp_stall;
  assign hit         = cmp_vld && (key_rdata.key == cur.key);
  assign issuing     = issue_cnt < keys_used;
  assign search_miss = !issuing && !cmp_vld;
  assign req_stall   = (state != S_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_SEARCH;
      end
      S_SEARCH: begin
        if (hit) begin
          if (cur.action == ACT_FIND && key_rdata.cnt != '0) state_next = S_FIND;
          else state_next = S_RESP;
        end else if (search_miss) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (can_load) state_next = S_IDLE;
      end
      S_FIND: begin
        if (pend && can_load && pend_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory and response controls
  always_comb begin
    key_rd_en        = 1'b0;
    key_raddr        = issue_cnt[KEY_AW-1:0];
    key_we           = 1'b0;
    key_waddr        = cmp_idx;
    key_wdata        = '{cnt: '0, key: cur.key};
    val_we           = 1'b0;
    val_waddr        = VAL_AW'(cmp_idx) * VAL_AW'(VALUES_PER_KEY) + VAL_AW'(key_rdata.cnt);
    val_rd_en        = 1'b0;
    val_raddr        = VAL_AW'(slot) * VAL_AW'(VALUES_PER_KEY) + VAL_AW'(fidx);
    resp_set         = 1'b0;
    resp_status_next = ST_STORED;
    keys_inc         = 1'b0;
    find_init        = 1'b0;
    rsp_load_single  = 1'b0;
    rsp_load_val     = 1'b0;
    unique case (state)
      S_IDLE: begin
      end
      S_SEARCH: begin
        if (hit) begin
          if (cur.action == ACT_INSERT) begin
            resp_set = 1'b1;
            if (key_rdata.cnt >= VCNT_W'(VALUES_PER_KEY)) begin
              resp_status_next = ST_LIST_FULL;
            end else begin
              // append to an existing list
              resp_status_next = ST_STORED;
              key_we           = 1'b1;
              key_wdata.cnt    = VCNT_W'(key_rdata.cnt + 1'b1);
              val_we           = 1'b1;
            end
          end else if (key_rdata.cnt == '0) begin
            resp_set         = 1'b1;
            resp_status_next = ST_NOT_FOUND;
          end else begin
            find_init = 1'b1;
          end
        end else if (issuing) begin
          key_rd_en = 1'b1;
        end else if (search_miss) begin
          resp_set = 1'b1;
          if (cur.action == ACT_FIND) begin
            resp_status_next = ST_NOT_FOUND;
          end else if (keys_used == KCNT_W'(MAX_KEYS)) begin
            resp_status_next = ST_KEYS_FULL;
          end else begin
            // claim the next free slot
            resp_status_next = ST_STORED;
            keys_inc         = 1'b1;
            key_we           = 1'b1;
            key_waddr        = keys_used[KEY_AW-1:0];
            key_wdata.cnt    = VCNT_W'(1);
            val_we           = 1'b1;
            val_waddr        = VAL_AW'(keys_used[KEY_AW-1:0]) * VAL_AW'(VALUES_PER_KEY);
          end
        end
      end
      S_RESP: begin
        rsp_load_single = can_load;
      end
      S_FIND: begin
        rsp_load_val = pend && can_load;
        // read ahead only when the read data register frees up
        val_rd_en    = (fidx < fcnt) && (!pend || can_load);
      end
      default: begin
      end
    endcase
  end

  // Key memory
  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_waddr] <= key_wdata;
    if (key_rd_en) key_rdata <= key_mem[key_raddr];
  end

  // Value memory
  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_waddr] <= cur.value;
    if (val_rd_en) val_rdata <= val_mem[val_raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      keys_used <= '0;
      cmp_vld   <= 1'b0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cmp_vld <= key_rd_en;
      if (keys_inc) keys_used <= KCNT_W'(keys_used + 1'b1);
      if (find_init) pend <= 1'b0;
      else if (val_rd_en) pend <= 1'b1;
      else if (rsp_load_val) pend <= 1'b0;
      if (rsp_load_single || rsp_load_val) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      cur       <= req;
      issue_cnt <= '0;
    end
    if (key_rd_en) begin
      issue_cnt <= KCNT_W'(issue_cnt + 1'b1);
      cmp_idx   <= key_raddr;
    end
    if (resp_set) resp_status <= resp_status_next;
    if (find_init) begin
      slot <= cmp_idx;
      fcnt <= key_rdata.cnt;
      fidx <= '0;
    end else if (val_rd_en) begin
      fidx      <= VCNT_W'(fidx + 1'b1);
      pend_last <= (VCNT_W'(fidx + 1'b1) == fcnt);
    end
    if (rsp_load_single) begin
      rsp.status      <= resp_status;
      rsp.found_value <= '0;
      rsp.last        <= 1'b1;
    end else if (rsp_load_val) begin
      rsp.status      <= ST_FOUND;
      rsp.found_value <= val_rdata;
      rsp.last        <= pend_last;
    end
  end

  // Checks
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_FOUND |-> rsp.last)
    else $error("non-find response without last");

  a_single_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_FOUND |-> rsp.found_value == '0)
    else $error("non-find response carries a value");

  a_keys_bound: assert property (@(posedge clk) disable iff (rst)
    keys_used <= KCNT_W'(MAX_KEYS))
    else $error("slot count beyond key table");

  a_pend_in_find: assert property (@(posedge clk) disable iff (rst)
    state != S_FIND |-> !pend)
    else $error("value read pending outside find streaming");

endmodule

// File: tb/sv/tb_key_multivalue_store.sv
module tb_key_multivalue_store;
  import kms_pkg::*;

  // Request waiting in the backlog, with the idle cycles that follow its transaction
  typedef struct {
    req_t r;
    int   gap;
  } queued_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  key_multivalue_store dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Shadow copy of the store contents
  logic signed [31:0] key_slots [MAX_KEYS];
  logic signed [31:0] slot_values [MAX_KEYS][VALUES_PER_KEY];
  int unsigned        slot_fill [MAX_KEYS];
  int unsigned        slots_taken = 0;

  queued_req_t req_backlog [$];
  rsp_t        due_rsp [$];
  bit          mismatch_seen = 1'b0;

  function automatic rsp_t make_rsp(status_t s, logic signed [31:0] v, logic l);
    rsp_t o;
    o.status      = s;
    o.found_value = v;
    o.last        = l;
    return o;
  endfunction

  // Append one owed response at the tail of the expected list
  function automatic void add_due(rsp_t o);
    due_rsp.insert(due_rsp.size(), o);
  endfunction

  // Apply one accepted request to the shadow store and queue the results it owes
  function automatic void apply_store_op(req_t r);
    int slot;
    slot = -1;
    for (int i = 0; i < slots_taken; i++) begin
      if (key_slots[i] == r.key) begin
        slot = i;
        break;
      end
    end
    if (r.action == ACT_INSERT) begin
      if (slot >= 0) begin
        if (slot_fill[slot] >= VALUES_PER_KEY) begin
          add_due(make_rsp(ST_LIST_FULL, '0, 1'b1));
        end else begin
          slot_values[slot][slot_fill[slot]] = r.value;
          slot_fill[slot]++;
          add_due(make_rsp(ST_STORED, '0, 1'b1));
        end
      end else if (slots_taken >= MAX_KEYS) begin
        add_due(make_rsp(ST_KEYS_FULL, '0, 1'b1));
      end else begin
        key_slots[slots_taken]      = r.key;
        slot_values[slots_taken][0] = r.value;
        slot_fill[slots_taken]      = 1;
        slots_taken++;
        add_due(make_rsp(ST_STORED, '0, 1'b1));
      end
    end else if (slot < 0) begin
      add_due(make_rsp(ST_NOT_FOUND, '0, 1'b1));
    end else begin
      for (int i = 0; i < slot_fill[slot]; i++) begin
        add_due(make_rsp(ST_FOUND, slot_values[slot][i],
                         (i + 1 == slot_fill[slot])));
      end
    end
  endfunction

  function automatic void queue_req(act_t a, logic signed [31:0] k,
                                    logic signed [31:0] v, int gap);
    queued_req_t q;
    q.r.action = a;
    q.r.key    = k;
    q.r.value  = v;
    q.gap      = gap;
    req_backlog.insert(req_backlog.size(), q);
  endfunction

  // Request driver: one transaction at a time, idle gap after each
  int          send_wait = 0;
  queued_req_t next_req;
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_wait = 0;
    end else if (!(req_valid && req_stall)) begin
      if (req_valid) begin
        apply_store_op(req);
      end
      if (send_wait > 0) begin
        send_wait--;
        req_valid <= 1'b0;
      end else if (req_backlog.size() != 0) begin
        next_req = req_backlog.pop_front();
        req       <= next_req.r;
        req_valid <= 1'b1;
        send_wait = next_req.gap;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response monitor: check each response, then hold off for a drawn or set number of cycles
  int rsp_seen  = 0;
  int hold_left = 0;
  rsp_t want;
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (due_rsp.size() == 0) begin
          $display("%0t: unexpected response status=%0d value=%0d last=%0b",
                   $time, rsp.status, rsp.found_value, rsp.last);
          mismatch_seen = 1'b1;
        end else begin
          want = due_rsp.pop_front();
          if (rsp.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
            mismatch_seen = 1'b1;
          end
          if (rsp.found_value !== want.found_value) begin
            $display("%0t: found_value expected %0d actual %0d",
                     $time, want.found_value, rsp.found_value);
            mismatch_seen = 1'b1;
          end
          if (rsp.last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, rsp.last);
            mismatch_seen = 1'b1;
          end
        end
        rsp_seen++;
        // long back-pressure once, a clean stretch later, random otherwise
        if (rsp_seen == 120) begin
          hold_left = 150;
        end else if (rsp_seen >= 250 && rsp_seen < 350) begin
          hold_left = 0;
        end else begin
          hold_left = $urandom_range(0, 6);
        end
      end else if (hold_left > 0) begin
        hold_left--;
      end
      rsp_stall <= (hold_left > 0);
    end
  end

  // Watchdog
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= 200000) begin
      $display("FAIL key_multivalue_store");
      $finish;
    end
  end

  // Stimulus and end of run
  logic signed [31:0] key_pool [24];
  initial begin
    int gap;
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7FFF_FFFF;
    key_pool[2] = 32'sh0000_0000;
    key_pool[3] = 32'shFFFF_FFFF;
    key_pool[4] = 32'sh5A5A_5A5A;
    for (int i = 5; i < 24; i++) begin
      key_pool[i] = $urandom;
    end

    // directed: empty find, extreme keys and values, a list run to full, hit and miss
    queue_req(ACT_FIND, 32'sh0, 32'shFFFF_FFFF, $urandom_range(0, 6));
    queue_req(ACT_INSERT, key_pool[0], 32'sh7FFF_FFFF, $urandom_range(0, 6));
    queue_req(ACT_INSERT, key_pool[1], 32'sh8000_0000, $urandom_range(0, 6));
    queue_req(ACT_INSERT, key_pool[2], 32'sh0, $urandom_range(0, 6));
    queue_req(ACT_INSERT, key_pool[3], 32'shFFFF_FFFF, $urandom_range(0, 6));
    queue_req(ACT_FIND, key_pool[0], 32'sh0, $urandom_range(0, 6));
    queue_req(ACT_FIND, key_pool[1], 32'sh0, $urandom_range(0, 6));
    queue_req(ACT_FIND, key_pool[2], 32'sh0, $urandom_range(0, 6));
    for (int i = 0; i < VALUES_PER_KEY + 1; i++) begin
      queue_req(ACT_INSERT, key_pool[4], $urandom, $urandom_range(0, 6));
    end
    queue_req(ACT_FIND, key_pool[4], 32'sh0, $urandom_range(0, 6));
    queue_req(ACT_FIND, 32'sh1234_5678, 32'sh0, $urandom_range(0, 6));

    // random: mostly pooled keys so lists and the key table fill, some wild keys
    for (int i = 0; i < 400; i++) begin
      gap = (i >= 200 && i < 260) ? 0 : $urandom_range(0, 6);
      if ($urandom_range(0, 99) < 15) begin
        queue_req(act_t'($urandom_range(0, 1)), $urandom, $urandom, gap);
      end else if ($urandom_range(0, 99) < 55) begin
        queue_req(ACT_INSERT, key_pool[$urandom_range(0, 23)], $urandom, gap);
      end else begin
        queue_req(ACT_FIND, key_pool[$urandom_range(0, 23)], $urandom, gap);
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (req_backlog.size() != 0 || req_valid || due_rsp.size() != 0) begin
      @(negedge clk);
    end
    repeat (40) @(posedge clk);

    if (!mismatch_seen && due_rsp.size() == 0) begin
      $display("PASS key_multivalue_store");
    end else begin
      $display("FAIL key_multivalue_store");
    end
    $finish;
  end

endmodule
